// ----- sv/buddy_block_allocator_defines.svh -----
// Assertion macros for the buddy block allocator.
// Included by the modules that carry assertions; no dependencies.
`ifndef BUDDY_BLOCK_ALLOCATOR_DEFINES_SVH
`define BUDDY_BLOCK_ALLOCATOR_DEFINES_SVH
`ifndef SYNTHESIS
`define BBA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("buddy allocator assertion failed");
`define BBA_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("buddy allocator assertion failed");
`else
`define BBA_ASSERT(lbl, prop)
`define BBA_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

// ----- sv/bba_pkg.sv -----
// Package of the buddy block allocator: sizes, entry layout, status codes
// and the command and status types between controller and datapath.
`timescale 1ns / 1ps
package bba_pkg;
  localparam int POOL_BLOCKS_LOG2 = 10;
  localparam int BLOCK_BYTES_LOG2 = 6;
  localparam int IDX_W = POOL_BLOCKS_LOG2;
  localparam int NBLK = 1 << POOL_BLOCKS_LOG2;
  localparam int ORD_W = 5;
  localparam int TOP_ORDER = POOL_BLOCKS_LOG2;
  localparam logic [ORD_W-1:0] TOP_ORD = ORD_W'(POOL_BLOCKS_LOG2);
  localparam logic [63:0] POOL_BYTES = 64'(1) << (POOL_BLOCKS_LOG2 + BLOCK_BYTES_LOG2);

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_FAIL = 2'd1;
  localparam logic [1:0] ST_IGNORED = 2'd2;

  typedef struct packed {
    logic             free;
    logic             used;
    logic [ORD_W-1:0] order;
  } entry_t;

  typedef enum logic [3:0] {
    DP_NOP, DP_CLR, DP_LOAD, DP_SCAN, DP_PICK, DP_SPLIT, DP_GRANT,
    DP_FRD, DP_FCHK, DP_BRD, DP_BCHK, DP_FFIN
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic       res_load;
    logic [1:0] res_status;
    logic       res_grant;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic scan_last;
    logic pick_ok;
    logic split_done;
    logic used_ok;
    logic at_top;
    logic merge;
    logic kind;
    logic too_big;
    logic oob;
  } dp_stat_t;
endpackage

// ----- sv/bba_if.sv -----
// Valid/ready channel interfaces of the buddy block allocator.
// Depends on nothing.
`timescale 1ns / 1ps
interface bba_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [31:0] request_bytes;
  logic [31:0] free_offset;
  modport source (output valid, kind, request_bytes, free_offset, input ready);
  modport sink (input valid, kind, request_bytes, free_offset, output ready);
endinterface

interface bba_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [15:0] block_offset;
  modport source (output valid, status, block_offset, input ready);
  modport sink (input valid, status, block_offset, output ready);
endinterface

// ----- sv/bba_datapath.sv -----
// Datapath of the buddy block allocator: the block state memory, scan,
// split and merge registers, and the result register. Uses bba_pkg.
`timescale 1ns / 1ps
module bba_datapath (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_kind,
  input  logic [31:0]       in_request_bytes,
  input  logic [31:0]       in_free_offset,
  input  bba_pkg::dp_cmd_t  cmd,
  output bba_pkg::dp_stat_t stat,
  output logic [1:0]        res_status,
  output logic [15:0]       res_offset
);
  import bba_pkg::*;

  localparam int OFF_W = IDX_W + BLOCK_BYTES_LOG2;
  localparam int EXT_W = (OFF_W > 16) ? OFF_W : 16;

  entry_t mem [NBLK];
  entry_t rd_data_r;

  logic [IDX_W-1:0] clr_cnt_r, scan_cnt_r, scan_addr_r, cur_idx_r;
  logic             scan_pend_r, kind_r, too_big_r, oob_r, pick_ok_r, cur_used_r;
  logic [ORD_W-1:0] ord_r, cur_k_r, cur_ord_r;
  logic [TOP_ORDER:0] found_r;
  logic [IDX_W-1:0] found_idx_r [TOP_ORDER+1];
  logic [1:0]       res_status_r;
  logic [15:0]      res_offset_r;

  logic             wr_en, rd_en;
  logic [IDX_W-1:0] wr_addr, rd_addr, bud;
  entry_t           wr_data;
  logic             merge;
  logic [ORD_W-1:0] ord_calc, pick_k, cap_ord;
  logic [IDX_W-1:0] pick_idx;
  logic             pick_ok;
  logic [EXT_W-1:0] off_ext;

  assign bud = cur_idx_r ^ (IDX_W'(1) << cur_ord_r);
  assign merge = rd_data_r.free && (rd_data_r.order == cur_ord_r);
  assign cap_ord = (rd_data_r.order > TOP_ORD) ? TOP_ORD : rd_data_r.order;
  assign off_ext = EXT_W'(cur_idx_r) << BLOCK_BYTES_LOG2;

  // Smallest order whose size holds the request, capped at the top order.
  always_comb begin
    ord_calc = TOP_ORD;
    for (int o = TOP_ORDER - 1; o >= 0; o--) begin
      if ((64'(1) << (BLOCK_BYTES_LOG2 + o)) >= {32'b0, in_request_bytes}) begin
        ord_calc = ORD_W'(o);
      end
    end
  end

  // Lowest order at or above the request that has a free block.
  always_comb begin
    pick_ok = 1'b0;
    pick_k = '0;
    pick_idx = '0;
    for (int o = TOP_ORDER; o >= 0; o--) begin
      if (found_r[o] && (ORD_W'(o) >= ord_r)) begin
        pick_ok = 1'b1;
        pick_k = ORD_W'(o);
        pick_idx = found_idx_r[o];
      end
    end
  end

  always_comb begin
    wr_en = 1'b0;
    rd_en = 1'b0;
    wr_addr = cur_idx_r;
    rd_addr = cur_idx_r;
    wr_data = '0;
    case (cmd.op)
      DP_CLR: begin
        wr_en = 1'b1;
        wr_addr = clr_cnt_r;
        wr_data = (clr_cnt_r == '0) ? entry_t'{1'b1, 1'b0, TOP_ORD} : '0;
      end
      DP_SCAN: begin
        rd_en = 1'b1;
        rd_addr = scan_cnt_r;
      end
      DP_SPLIT: begin
        if (cur_k_r != ord_r) begin
          wr_en = 1'b1;
          wr_addr = cur_idx_r | (IDX_W'(1) << (cur_k_r - ORD_W'(1)));
          wr_data = entry_t'{1'b1, 1'b0, cur_k_r - ORD_W'(1)};
        end
      end
      DP_GRANT: begin
        wr_en = 1'b1;
        wr_data = entry_t'{1'b0, 1'b1, ord_r};
      end
      DP_FRD: rd_en = 1'b1;
      DP_FCHK: begin
        wr_en = rd_data_r.used;
        wr_data = entry_t'{rd_data_r.free, 1'b0, rd_data_r.order};
      end
      DP_BRD: begin
        rd_en = 1'b1;
        rd_addr = bud;
      end
      DP_BCHK: begin
        wr_en = merge;
        wr_addr = bud;
        wr_data = entry_t'{1'b0, rd_data_r.used, rd_data_r.order};
      end
      DP_FFIN: begin
        wr_en = 1'b1;
        wr_data = entry_t'{1'b1, cur_used_r, cur_ord_r};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
      scan_pend_r <= 1'b0;
    end else begin
      scan_pend_r <= (cmd.op == DP_SCAN);
      if (cmd.op == DP_CLR) clr_cnt_r <= clr_cnt_r + IDX_W'(1);
    end
    scan_addr_r <= scan_cnt_r;
    if (scan_pend_r) begin
      for (int o = 0; o <= TOP_ORDER; o++) begin
        if (rd_data_r.free && (rd_data_r.order == ORD_W'(o)) && !found_r[o]) begin
          found_r[o] <= 1'b1;
          found_idx_r[o] <= scan_addr_r;
        end
      end
    end
    case (cmd.op)
      DP_LOAD: begin
        kind_r <= in_kind;
        too_big_r <= {32'b0, in_request_bytes} > POOL_BYTES;
        oob_r <= {32'b0, in_free_offset} >= POOL_BYTES;
        ord_r <= ord_calc;
        cur_idx_r <= IDX_W'(in_free_offset >> BLOCK_BYTES_LOG2);
        scan_cnt_r <= '0;
        found_r <= '0;
      end
      DP_SCAN: scan_cnt_r <= scan_cnt_r + IDX_W'(1);
      DP_PICK: begin
        pick_ok_r <= pick_ok;
        cur_k_r <= pick_k;
        cur_idx_r <= pick_idx;
      end
      DP_SPLIT: if (cur_k_r != ord_r) cur_k_r <= cur_k_r - ORD_W'(1);
      DP_FCHK: begin
        cur_ord_r <= cap_ord;
        cur_used_r <= 1'b0;
      end
      DP_BCHK: begin
        if (merge) begin
          if (bud < cur_idx_r) begin
            cur_idx_r <= bud;
            cur_used_r <= rd_data_r.used;
          end
          cur_ord_r <= cur_ord_r + ORD_W'(1);
        end
      end
      default: ;
    endcase
    if (cmd.res_load) begin
      res_status_r <= cmd.res_status;
      res_offset_r <= cmd.res_grant ? off_ext[15:0] : 16'd0;
    end
  end

  assign res_status = res_status_r;
  assign res_offset = res_offset_r;

  always_comb begin
    stat.clr_done = (clr_cnt_r == '1);
    stat.scan_last = (scan_cnt_r == '1);
    stat.pick_ok = pick_ok_r;
    stat.split_done = (cur_k_r == ord_r);
    stat.used_ok = rd_data_r.used;
    stat.at_top = (cur_ord_r == TOP_ORD);
    stat.merge = merge;
    stat.kind = kind_r;
    stat.too_big = too_big_r;
    stat.oob = oob_r;
  end
endmodule

// ----- sv/bba_controller.sv -----
// Controller state machine of the buddy block allocator: sequences the
// datapath and runs the channel handshakes. Uses bba_pkg and the defines.
`timescale 1ns / 1ps
`include "buddy_block_allocator_defines.svh"
module bba_controller (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output bba_pkg::dp_cmd_t  cmd,
  input  bba_pkg::dp_stat_t stat
);
  import bba_pkg::*;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_DISP, S_SCAN, S_DRAIN, S_PICK, S_PCHK, S_SPLIT,
    S_GRANT, S_FRD, S_FCHK, S_BRD, S_BCHK, S_FFIN, S_RES
  } state_t;

  state_t     state_r;
  logic       out_valid_r;
  logic [1:0] res_code_r;
  logic       res_grant_r;
  logic       res_load;

  assign in_ready = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign res_load = (state_r == S_RES) && (!out_valid_r || out_ready);

  always_comb begin
    cmd.op = DP_NOP;
    cmd.res_load = res_load;
    cmd.res_status = res_code_r;
    cmd.res_grant = res_grant_r;
    case (state_r)
      S_CLR: cmd.op = DP_CLR;
      S_IDLE: cmd.op = in_valid ? DP_LOAD : DP_NOP;
      S_SCAN: cmd.op = DP_SCAN;
      S_PICK: cmd.op = DP_PICK;
      S_SPLIT: cmd.op = DP_SPLIT;
      S_GRANT: cmd.op = DP_GRANT;
      S_FRD: cmd.op = DP_FRD;
      S_FCHK: cmd.op = DP_FCHK;
      S_BRD: cmd.op = DP_BRD;
      S_BCHK: cmd.op = DP_BCHK;
      S_FFIN: cmd.op = DP_FFIN;
      default: cmd.op = DP_NOP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      out_valid_r <= 1'b0;
      res_code_r <= ST_OK;
      res_grant_r <= 1'b0;
    end else begin
      if (res_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      case (state_r)
        S_CLR: if (stat.clr_done) state_r <= S_IDLE;
        S_IDLE: if (in_valid) state_r <= S_DISP;
        S_DISP: begin
          res_grant_r <= 1'b0;
          if (!stat.kind) begin
            res_code_r <= ST_FAIL;
            state_r <= stat.too_big ? S_RES : S_SCAN;
          end else begin
            res_code_r <= ST_IGNORED;
            state_r <= stat.oob ? S_RES : S_FRD;
          end
        end
        S_SCAN: if (stat.scan_last) state_r <= S_DRAIN;
        S_DRAIN: state_r <= S_PICK;
        S_PICK: state_r <= S_PCHK;
        S_PCHK: state_r <= stat.pick_ok ? S_SPLIT : S_RES;
        S_SPLIT: if (stat.split_done) state_r <= S_GRANT;
        S_GRANT: begin
          res_code_r <= ST_OK;
          res_grant_r <= 1'b1;
          state_r <= S_RES;
        end
        S_FRD: state_r <= S_FCHK;
        S_FCHK: state_r <= stat.used_ok ? S_BRD : S_RES;
        S_BRD: state_r <= stat.at_top ? S_FFIN : S_BCHK;
        S_BCHK: state_r <= stat.merge ? S_BRD : S_FFIN;
        S_FFIN: begin
          res_code_r <= ST_OK;
          state_r <= S_RES;
        end
        S_RES: if (res_load) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `BBA_ASSERT(a_no_accept_clearing, (state_r == S_CLR) |-> !in_ready)
  `BBA_ASSERT(a_grant_then_result, (cmd.op == DP_GRANT) |=> (state_r == S_RES))
  `BBA_ASSERT(a_load_into_free_slot, res_load |-> (!out_valid_r || out_ready))
  `BBA_ASSERT_ALWAYS(a_reset_drops_result, !rst_n |=> !out_valid)
endmodule

// ----- sv/buddy_block_allocator.sv -----
// Buddy block allocator: binary buddy allocation over a pool of
// 1024 blocks of 64 bytes each.
//
// in_item carries one request per item: kind 0 allocates request_bytes,
// kind 1 frees the block at free_offset. out_item returns exactly one
// result per request: status (0 success, 1 allocation failed, 2 free
// ignored) and block_offset, the byte offset granted on allocation
// success and zero otherwise.
// Requests are handled one at a time. An allocation scans the state
// memory once, one entry per cycle, for the lowest free block of every
// order, then splits the chosen block down to the requested order, or
// fails when none fits. An oversized allocation or an out-of-range free
// goes straight to its result; a free of an unallocated block is ignored,
// and a free merges with its free buddy order by order until that buddy
// is not free or the top order is reached. After reset the state memory
// is cleared, one entry per cycle, and in_item.ready stays low until done.
// A finished result sits in an output register; the next request is
// accepted while it waits, but its own result is held back until
// out_item has taken the previous one.
// Uses bba_pkg, bba_if, bba_controller and bba_datapath.
`timescale 1ns / 1ps
module buddy_block_allocator (
  input logic clk,
  input logic rst_n,
  bba_in_if.sink in_item,
  bba_out_if.source out_item
);
  import bba_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // The controller owns the handshakes and sequencing.
  bba_controller u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_item.valid),
    .in_ready  (in_item.ready),
    .out_valid (out_item.valid),
    .out_ready (out_item.ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  // The datapath holds the block state and the result register.
  bba_datapath u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_kind          (in_item.kind),
    .in_request_bytes (in_item.request_bytes),
    .in_free_offset   (in_item.free_offset),
    .cmd              (cmd),
    .stat             (stat),
    .res_status       (out_item.status),
    .res_offset       (out_item.block_offset)
  );
endmodule
